// ===== rtl/tlv_var_number_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef TLV_VAR_NUMBER_DECODER_DEFINES_SVH
`define TLV_VAR_NUMBER_DECODER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define TLVD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define TLVD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlvd_pkg.sv =====
package tlvd_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned USED_W = 5;
    localparam int unsigned TOGO_W = 4;
    localparam int unsigned PHASE_W = 2;

    localparam logic [7:0] MARK_TWO = 8'd253;
    localparam logic [7:0] MARK_FOUR = 8'd254;
    localparam logic [7:0] MARK_EIGHT = 8'd255;
    localparam logic [TOGO_W-1:0] MAX_INT_LEN = 4'd8;

    localparam logic [USED_W-1:0] USED_MIN = 5'd1;
    localparam logic [USED_W-1:0] USED_MAX = 5'd17;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WIDE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADLEN = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   bytes_used;
    } tlvd_result_t;

endpackage

// ===== rtl/tlvd_core.sv =====
module tlvd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wide_numbers,
    input  logic                 in_accept,
    input  logic                 func,
    input  logic [7:0]           data_byte,
    input  logic                 buffer_end,
    output logic                 res_valid,
    output tlvd_pkg::tlvd_result_t res
);
    import tlvd_pkg::*;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_NUM = 2'd1;
    localparam logic [PHASE_W-1:0] PH_INT = 2'd2;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TOGO_W-1:0]  togo_reg, togo_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               mode_reg, mode_next;
    logic [USED_W-1:0]  count_reg, count_next;

    logic               active;
    logic               fin;
    logic               num_done;
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] shifted;
    logic [TOGO_W-1:0]  togo_dec;
    logic [VALUE_W-1:0] fin_value;
    logic [STATUS_W-1:0] fin_status;
    logic               len_ok;

    assign active = (phase_reg == PH_NUM) || (phase_reg == PH_INT);
    assign shifted = {acc_reg[VALUE_W-9:0], data_byte};
    assign togo_dec = (togo_reg != '0) ? togo_reg - 4'd1 : '0;

    always_comb begin
        phase_next = phase_reg;
        togo_next = togo_reg;
        acc_next = acc_reg;
        mode_next = mode_reg;
        count_next = count_reg;
        fin = 1'b0;
        fin_value = '0;
        fin_status = ST_OK;
        num_done = 1'b0;
        num = '0;
        len_ok = 1'b0;
        res_valid = 1'b0;
        res = '0;

        if (in_accept) begin
            if (!active) begin
                mode_next = func;
                count_next = USED_MIN;
                acc_next = '0;
                if (data_byte < MARK_TWO) begin
                    num_done = 1'b1;
                    num = {{(VALUE_W-8){1'b0}}, data_byte};
                end else if (data_byte == MARK_EIGHT && !wide_numbers) begin
                    fin = 1'b1;
                    fin_status = ST_WIDE;
                end else begin
                    if (data_byte == MARK_TWO) begin
                        togo_next = 4'd2;
                    end else if (data_byte == MARK_FOUR) begin
                        togo_next = 4'd4;
                    end else begin
                        togo_next = MAX_INT_LEN;
                    end
                    if (buffer_end) begin
                        fin = 1'b1;
                        fin_status = ST_TRUNC;
                    end else begin
                        phase_next = PH_NUM;
                    end
                end
            end else begin
                acc_next = shifted;
                count_next = count_reg + 5'd1;
                togo_next = togo_dec;
                if (togo_dec == '0) begin
                    if (phase_reg == PH_NUM) begin
                        num_done = 1'b1;
                        num = shifted;
                    end else begin
                        fin = 1'b1;
                        fin_value = shifted;
                    end
                end else if (buffer_end) begin
                    fin = 1'b1;
                    fin_status = ST_TRUNC;
                end
            end

            // A finished var-number is either the result or an integer's length.
            if (num_done) begin
                len_ok = (num == 64'd1) || (num == 64'd2) || (num == 64'd4)
                    || (num == {{(VALUE_W-TOGO_W){1'b0}}, MAX_INT_LEN});
                if (!mode_next) begin
                    fin = 1'b1;
                    fin_value = num;
                end else if (!len_ok) begin
                    fin = 1'b1;
                    fin_status = ST_BADLEN;
                end else if (buffer_end) begin
                    fin = 1'b1;
                    fin_status = ST_TRUNC;
                end else begin
                    phase_next = PH_INT;
                    togo_next = num[TOGO_W-1:0];
                    acc_next = '0;
                end
            end

            if (fin) begin
                res_valid = 1'b1;
                res.value = fin_value;
                res.status = fin_status;
                res.bytes_used = count_next;
                phase_next = PH_IDLE;
                togo_next = '0;
                acc_next = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            togo_reg <= '0;
            acc_reg <= '0;
            mode_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            togo_reg <= togo_next;
            acc_reg <= acc_next;
            mode_reg <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/tlv_var_number_decoder.sv =====
// Channel  | Dir | Contents
// s_*      | in  | tdata[7:0] data_byte, tuser func, tlast buffer_end
// m_*      | out | tdata[63:0] value, tdata[68:64] bytes_used, tuser status
// cfg_*    | in  | cfg_data wide_numbers
//
// One input word is taken per cycle while s_tready is high; the result of the word
// that completes or fails a field is registered into the output buffer.
// A two-entry output buffer (main register plus skid register) lets input
// continue while m_tready is low; s_tready drops only while the skid register
// holds a result. Reset is synchronous, active low, and clears the decode
// state, the output buffer and wide_numbers.
`include "tlv_var_number_decoder_defines.svh"

module tlv_var_number_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] value, [68:64] bytes_used, [71:69] zero
    output logic [tlvd_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import tlvd_pkg::*;

    logic          wide_reg;
    logic          in_accept;
    logic          res_valid;
    tlvd_result_t  res;
    logic          main_valid_reg;
    tlvd_result_t  main_reg;
    logic          skid_valid_reg;
    tlvd_result_t  skid_reg;
    logic          pop;

    assign cfg_ready = 1'b1;
    assign s_tready = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign pop = main_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            wide_reg <= cfg_data;
        end
    end

    tlvd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wide_numbers (wide_reg),
        .in_accept    (in_accept),
        .func         (s_tuser),
        .data_byte    (s_tdata),
        .buffer_end   (s_tlast),
        .res_valid    (res_valid),
        .res          (res)
    );

    // The skid register fills only when a result arrives while the main
    // register is full and not being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (res_valid) begin
            if (!main_valid_reg || pop) begin
                main_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata = {3'b000, main_reg.bytes_used, main_reg.value};
    assign m_tuser = main_reg.status;

    `TLVD_ASSERT_NOW(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg, "skid register full while output register is empty")
    `TLVD_ASSERT_NOW(a_error_value_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata[63:0] == 64'd0, "failed field carries a nonzero value")
    `TLVD_ASSERT_NOW(a_used_in_range, aclk, aresetn, m_tvalid, (m_tdata[68:64] >= USED_MIN) && (m_tdata[68:64] <= USED_MAX), "bytes_used out of range")
    `TLVD_ASSERT_NEXT(a_result_kept, aclk, aresetn, res_valid && skid_valid_reg, 1'b0, "result produced while the output buffer was full")

endmodule
